/* rtl/core/ptrt_pkg.sv */
// Package: shared constants, types and helpers for the point transform.
package ptrt_pkg;

    localparam int GUARD_BITS = 8;
    localparam int ANGLE_BITS = 16;
    localparam int ZBITS      = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int GAIN_BITS  = 31;
    localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 31'd652032875;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_REF_X     = 3'd0,
        REG_REF_Y     = 3'd1,
        REG_REF_Z     = 3'd2,
        REG_ANGLE_XY1 = 3'd3,
        REG_ANGLE_XZ  = 3'd4,
        REG_ANGLE_XY2 = 3'd5
    } cfg_idx_t;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    // Quarter-turn count and residual angle of a 16-bit binary angle.
    typedef struct packed {
        logic [1:0]             quad;
        logic                   active;
        logic signed [ZBITS-1:0] zinit;
    } rot_ctl_t;

    function automatic logic signed [ZBITS-1:0] atan_entry(input int i);
        logic signed [ZBITS-1:0] r;
        unique case (i)
            0:  r = 32'sh20000000;
            1:  r = 32'sh12E4051E;
            2:  r = 32'sh09FB385B;
            3:  r = 32'sh051111D4;
            4:  r = 32'sh028B0D43;
            5:  r = 32'sh0145D7E1;
            6:  r = 32'sh00A2F61E;
            7:  r = 32'sh00517C55;
            8:  r = 32'sh0028BE53;
            9:  r = 32'sh00145F2F;
            10: r = 32'sh000A2F98;
            11: r = 32'sh000517CC;
            12: r = 32'sh00028BE6;
            13: r = 32'sh000145F3;
            14: r = 32'sh0000A2FA;
            15: r = 32'sh0000517D;
            16: r = 32'sh000028BE;
            17: r = 32'sh0000145F;
            18: r = 32'sh00000A30;
            19: r = 32'sh00000518;
            20: r = 32'sh0000028C;
            21: r = 32'sh00000146;
            22: r = 32'sh000000A3;
            23: r = 32'sh00000051;
            24: r = 32'sh00000029;
            25: r = 32'sh00000014;
            26: r = 32'sh0000000A;
            27: r = 32'sh00000005;
            28: r = 32'sh00000003;
            29: r = 32'sh00000001;
            30: r = 32'sh00000001;
            default: r = 32'sh00000000;
        endcase
        return r;
    endfunction

    function automatic rot_ctl_t decode_angle(input angle_t ang);
        rot_ctl_t c;
        logic [ANGLE_BITS-1:0] sum;
        logic [ANGLE_BITS-1:0] rr;
        sum = ang + 16'h2000;
        c.quad = sum[15:14];
        rr = ang - {c.quad, 14'd0};
        c.active = (rr != '0);
        // z = -r * 65536, r the signed residual
        c.zinit = -$signed({rr, 16'd0});
        return c;
    endfunction

endpackage

/* rtl/core/ptrt_if.sv */
// Interfaces: valid/ready point and config channels.
interface ptrt_point_if #(parameter int W = 24);
    logic               valid;
    logic               ready;
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic               saturated;
    modport source (output valid, x, y, z, saturated, input ready);
    modport sink   (input valid, x, y, z, saturated, output ready);
endinterface

interface ptrt_cfg_if #(parameter int W = 24);
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/point_translate_rotate_transform.sv */
// Top level: translate by reference point, three CORDIC rotations, round and saturate.
// One point per cycle unless the output stalls, fully pipelined through the input translate,
// per rotation a quarter-turn stage, two gain stages and ROTATION_STEPS CORDIC stages,
// then rounding into the output register. A stall on the result side freezes the whole
// pipeline; the output register holds its result and input ready follows output ready
// whenever the final stage is occupied.
module point_translate_rotate_transform #(
    parameter int COORD_BITS     = 24,
    parameter int ROTATION_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    ptrt_cfg_if.sink     cfg,
    ptrt_point_if.sink   in_pt,
    ptrt_point_if.source out_pt
);
    import ptrt_pkg::*;

    localparam int IW  = COORD_BITS + GUARD_BITS + 10;
    localparam int LAT = 3 * (ROTATION_STEPS + 3) + 1;

    logic signed [COORD_BITS-1:0] ref_x_reg, ref_y_reg, ref_z_reg;
    angle_t ang1_reg, ang2_reg, ang3_reg;
    rot_ctl_t c1, c2, c3;

    logic [LAT-1:0] vld_reg;
    logic           en;
    logic           out_valid_reg;

    logic signed [IW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [IW-1:0] r1x, r1y, r2x, r2z, r3x, r3y;
    logic signed [IW-1:0] y_d_reg [ROTATION_STEPS+3];

    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg;
    logic                         osat_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
            ang1_reg  <= '0;
            ang2_reg  <= '0;
            ang3_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_REF_X:     ref_x_reg <= cfg.data;
                REG_REF_Y:     ref_y_reg <= cfg.data;
                REG_REF_Z:     ref_z_reg <= cfg.data;
                REG_ANGLE_XY1: ang1_reg  <= cfg.data[ANGLE_BITS-1:0];
                REG_ANGLE_XZ:  ang2_reg  <= cfg.data[ANGLE_BITS-1:0];
                REG_ANGLE_XY2: ang3_reg  <= cfg.data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign c1 = decode_angle(ang1_reg);
    assign c2 = decode_angle(ang2_reg);
    assign c3 = decode_angle(ang3_reg);

    // pipeline advances unless a finished result is stuck
    assign en = !out_valid_reg || out_pt.ready;
    assign in_pt.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_pt.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // widen before subtracting so the difference cannot wrap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg <= (IW'($signed(in_pt.x)) - IW'($signed(ref_x_reg))) <<< GUARD_BITS;
            ty_reg <= (IW'($signed(in_pt.y)) - IW'($signed(ref_y_reg))) <<< GUARD_BITS;
            tz_reg <= (IW'($signed(in_pt.z)) - IW'($signed(ref_z_reg))) <<< GUARD_BITS;
        end
    end

    // z rides alongside the first rotation, y alongside the second
    logic signed [IW-1:0] z_d_reg [ROTATION_STEPS+3];
    for (genvar i = 0; i < ROTATION_STEPS + 3; i++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_d_reg[i] <= (i == 0) ? tz_reg : z_d_reg[(i == 0) ? 0 : i-1];
                y_d_reg[i] <= (i == 0) ? r1y    : y_d_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    ptrt_rotator #(.IW(IW), .STEPS(ROTATION_STEPS)) u_rot1 (
        .clk(clk), .en(en), .ctl(c1), .a(tx_reg), .b(ty_reg),
        .a_out(r1x), .b_out(r1y)
    );
    ptrt_rotator #(.IW(IW), .STEPS(ROTATION_STEPS)) u_rot2 (
        .clk(clk), .en(en), .ctl(c2), .a(r1x), .b(z_d_reg[ROTATION_STEPS+2]),
        .a_out(r2x), .b_out(r2z)
    );
    ptrt_rotator #(.IW(IW), .STEPS(ROTATION_STEPS)) u_rot3 (
        .clk(clk), .en(en), .ctl(c3), .a(r2x), .b(y_d_reg[ROTATION_STEPS+2]),
        .a_out(r3x), .b_out(r3y)
    );

    // z waits for the third rotation
    logic signed [IW-1:0] z2_d_reg [ROTATION_STEPS+3];
    for (genvar i = 0; i < ROTATION_STEPS + 3; i++)
    begin : g_dly2
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z2_d_reg[i] <= (i == 0) ? r2z : z2_d_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    localparam logic signed [IW-1:0] HI = IW'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [IW-1:0] LO = -HI - IW'(1);

    function automatic logic [COORD_BITS:0] finish(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] r;
        r = (v + IW'(1 <<< (GUARD_BITS-1))) >>> GUARD_BITS;
        if (r > HI)
            return {1'b1, HI[COORD_BITS-1:0]};
        else if (r < LO)
            return {1'b1, LO[COORD_BITS-1:0]};
        return {1'b0, r[COORD_BITS-1:0]};
    endfunction

    logic [COORD_BITS:0] fx, fy, fz;
    assign fx = finish(r3x);
    assign fy = finish(r3y);
    assign fz = finish(z2_d_reg[ROTATION_STEPS+2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg   <= fx[COORD_BITS-1:0];
            oy_reg   <= fy[COORD_BITS-1:0];
            oz_reg   <= fz[COORD_BITS-1:0];
            osat_reg <= fx[COORD_BITS] | fy[COORD_BITS] | fz[COORD_BITS];
        end
    end

    assign out_pt.valid     = out_valid_reg;
    assign out_pt.x         = ox_reg;
    assign out_pt.y         = oy_reg;
    assign out_pt.z         = oz_reg;
    assign out_pt.saturated = osat_reg;
endmodule

/* rtl/core/ptrt_gain.sv */
// Gain stage: scales both plane coordinates by the inverse CORDIC gain unless bypassed, 2 register stages.
module ptrt_gain #(
    parameter int IW = 42
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 bypass,
    input  logic signed [IW-1:0] a,
    input  logic signed [IW-1:0] b,
    output logic signed [IW-1:0] a_out,
    output logic signed [IW-1:0] b_out
);
    import ptrt_pkg::*;

    localparam int HW = IW - 15;
    localparam int PW = HW + GAIN_BITS + 1;
    localparam int LW = 15 + GAIN_BITS + 1;

    logic signed [PW-1:0] ahi_reg, bhi_reg;
    logic signed [LW-1:0] alo_reg, blo_reg;
    logic                 byp_reg;
    logic signed [IW-1:0] a_reg, b_reg;
    logic signed [PW-1:0] at, bt;
    logic signed [IW-1:0] a_next, b_next;
    logic signed [IW-1:0] a_out_reg, b_out_reg;

    // split product: hi*G + ((lo*G + 2^29) >>> 15), then >>> 15
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ahi_reg <= $signed(a[IW-1:15]) * $signed({1'b0, GAIN_Q30});
            bhi_reg <= $signed(b[IW-1:15]) * $signed({1'b0, GAIN_Q30});
            alo_reg <= $signed({1'b0, a[14:0]}) * $signed({1'b0, GAIN_Q30})
                       + LW'(64'sd536870912);
            blo_reg <= $signed({1'b0, b[14:0]}) * $signed({1'b0, GAIN_Q30})
                       + LW'(64'sd536870912);
            byp_reg <= bypass;
            a_reg   <= a;
            b_reg   <= b;
        end
    end

    always_comb
    begin
        at = ahi_reg + PW'(alo_reg >>> 15);
        bt = bhi_reg + PW'(blo_reg >>> 15);
        a_next = byp_reg ? a_reg : IW'(at >>> 15);
        b_next = byp_reg ? b_reg : IW'(bt >>> 15);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_out_reg <= a_next;
            b_out_reg <= b_next;
        end
    end

    assign a_out = a_out_reg;
    assign b_out = b_out_reg;
endmodule

/* rtl/core/ptrt_rotator.sv */
// Rotator: quarter turns, gain and pipelined CORDIC for one clockwise rotation.
module ptrt_rotator #(
    parameter int IW    = 42,
    parameter int STEPS = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  ptrt_pkg::rot_ctl_t   ctl,
    input  logic signed [IW-1:0] a,
    input  logic signed [IW-1:0] b,
    output logic signed [IW-1:0] a_out,
    output logic signed [IW-1:0] b_out
);
    import ptrt_pkg::*;

    logic signed [IW-1:0] qa_reg, qb_reg;
    logic                 act_reg;
    logic signed [ZBITS-1:0] z0_reg;
    logic signed [IW-1:0] ga, gb;
    logic                 act_d_reg;
    logic signed [ZBITS-1:0] z_d_reg;
    logic                 act_d2_reg;
    logic signed [ZBITS-1:0] z_d2_reg;

    logic signed [IW-1:0]    xs_reg [STEPS];
    logic signed [IW-1:0]    ys_reg [STEPS];
    logic signed [ZBITS-1:0] zs_reg [STEPS];
    logic                    as_reg [STEPS];

    // quarter turns: (x, y) -> (y, -x) each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (ctl.quad)
                2'd0:
                begin
                    qa_reg <= a;
                    qb_reg <= b;
                end
                2'd1:
                begin
                    qa_reg <= b;
                    qb_reg <= -a;
                end
                2'd2:
                begin
                    qa_reg <= -a;
                    qb_reg <= -b;
                end
                default:
                begin
                    qa_reg <= -b;
                    qb_reg <= a;
                end
            endcase
            act_reg <= ctl.active;
            z0_reg  <= ctl.zinit;
        end
    end

    ptrt_gain #(.IW(IW)) u_gain (
        .clk    (clk),
        .en     (en),
        .bypass (!act_reg),
        .a      (qa_reg),
        .b      (qb_reg),
        .a_out  (ga),
        .b_out  (gb)
    );

    // control follows the two gain stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_d_reg  <= act_reg;
            z_d_reg    <= z0_reg;
            act_d2_reg <= act_d_reg;
            z_d2_reg   <= z_d_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [IW-1:0]    xi, yi;
        logic signed [ZBITS-1:0] zi;
        logic                    ai;
        if (i == 0)
        begin : g_first
            assign xi = ga;
            assign yi = gb;
            assign zi = z_d2_reg;
            assign ai = act_d2_reg;
        end
        else
        begin : g_next
            assign xi = xs_reg[i-1];
            assign yi = ys_reg[i-1];
            assign zi = zs_reg[i-1];
            assign ai = as_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                as_reg[i] <= ai;
                if (!ai)
                begin
                    xs_reg[i] <= xi;
                    ys_reg[i] <= yi;
                    zs_reg[i] <= zi;
                end
                else if (!zi[ZBITS-1])
                begin
                    xs_reg[i] <= xi - (yi >>> i);
                    ys_reg[i] <= yi + (xi >>> i);
                    zs_reg[i] <= zi - atan_entry(i);
                end
                else
                begin
                    xs_reg[i] <= xi + (yi >>> i);
                    ys_reg[i] <= yi - (xi >>> i);
                    zs_reg[i] <= zi + atan_entry(i);
                end
            end
        end
    end

    assign a_out = xs_reg[STEPS-1];
    assign b_out = ys_reg[STEPS-1];
endmodule

/* rtl/core/ptrt_checker.sv */
// Checker: port-level properties of the point transform, bound to the top level.
module ptrt_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS-1:0] out_x,
    input logic                  out_sat,
    input logic                  cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_sat))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");
endmodule

bind point_translate_rotate_transform ptrt_checker #(.COORD_BITS(COORD_BITS)) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_pt.ready),
    .out_valid (out_pt.valid),
    .out_ready (out_pt.ready),
    .out_x     (out_pt.x),
    .out_sat   (out_pt.saturated),
    .cfg_ready (cfg.ready)
);
